/* rtl/core/escp_pkg.sv */
`default_nettype none

package escp_pkg;

	// Widths fixed by the external interface.
	localparam int CHAR_W     = 8;
	localparam int CFG_W      = 24;
	localparam int LINE_OUT_W = 24;

	// Byte classes worked out by the front end.
	localparam logic [3:0] KIND_OTHER   = 4'd0;
	localparam logic [3:0] KIND_COLON   = 4'd1;
	localparam logic [3:0] KIND_LBRACE  = 4'd2;
	localparam logic [3:0] KIND_RBRACE  = 4'd3;
	localparam logic [3:0] KIND_LPAREN  = 4'd4;
	localparam logic [3:0] KIND_COMMA   = 4'd5;
	localparam logic [3:0] KIND_RPAREN  = 4'd6;
	localparam logic [3:0] KIND_SLASH   = 4'd7;
	localparam logic [3:0] KIND_STAR    = 4'd8;
	localparam logic [3:0] KIND_NEWLINE = 4'd9;

	// Character codes the parser cares about.
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_FF      = 8'h0C;
	localparam logic [7:0] CH_VT      = 8'h0B;

	// Field the parser is currently filling.
	localparam logic [2:0] F_KEYWORD = 3'd0;
	localparam logic [2:0] F_NAME    = 3'd1;
	localparam logic [2:0] F_ARGS    = 3'd2;
	localparam logic [2:0] F_AFTER   = 3'd3;
	localparam logic [2:0] F_BODY    = 3'd4;

	// Destination codes.
	localparam logic [2:0] DEST_NONE = 3'd0;
	localparam logic [2:0] DEST_BODY = 3'd4;

	// Marker codes.
	localparam logic [1:0] MARK_NONE = 2'd0;
	localparam logic [1:0] MARK_NAME = 2'd1;
	localparam logic [1:0] MARK_ARGS = 2'd2;
	localparam logic [1:0] MARK_BODY = 2'd3;

	// Error codes.
	localparam logic [3:0] ERR_NONE           = 4'd0;
	localparam logic [3:0] ERR_COLON_IN_ARGS  = 4'd1;
	localparam logic [3:0] ERR_BRACE_IN_ARGS  = 4'd2;
	localparam logic [3:0] ERR_STRAY_RBRACE   = 4'd3;
	localparam logic [3:0] ERR_PAREN_IN_ARGS  = 4'd4;
	localparam logic [3:0] ERR_STRAY_COMMA    = 4'd5;
	localparam logic [3:0] ERR_STRAY_RPAREN   = 4'd6;
	localparam logic [3:0] ERR_MISSING_COMMA  = 4'd7;
	localparam logic [3:0] ERR_MISSING_RBRACE = 4'd8;
	localparam logic [3:0] ERR_MISSING_RPAREN = 4'd9;
	localparam logic [3:0] ERR_TOO_DEEP       = 4'd10;

	// Queue between front end and back end.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [3:0]        kind;
		logic              spacer;
		logic              eot;
	} entry_t;

	typedef struct packed {
		logic [CHAR_W-1:0]     out_char;
		logic [2:0]            dest;
		logic                  start_argument;
		logic                  close_element;
		logic [1:0]            marker;
		logic [LINE_OUT_W-1:0] line;
		logic [3:0]            error;
		logic                  stream_done;
		logic                  last_of_item;
	} evt_t;

endpackage

`default_nettype wire

/* rtl/core/escp_front.sv */
`default_nettype none

module escp_front (
	input  wire logic                        item_valid,
	output logic                             item_ready,
	input  wire logic [escp_pkg::CHAR_W-1:0] ch,
	input  wire logic                        end_of_text,
	output logic                             push_valid,
	input  wire logic                        push_ready,
	output escp_pkg::entry_t                 push_entry
);
	import escp_pkg::*;

	logic [3:0] kind;
	logic       spacer;

	// Sort the byte into the classes that the parser branches on.
	always_comb begin
		case (ch)
			CH_COLON:   kind = KIND_COLON;
			CH_LBRACE:  kind = KIND_LBRACE;
			CH_RBRACE:  kind = KIND_RBRACE;
			CH_LPAREN:  kind = KIND_LPAREN;
			CH_COMMA:   kind = KIND_COMMA;
			CH_RPAREN:  kind = KIND_RPAREN;
			CH_SLASH:   kind = KIND_SLASH;
			CH_STAR:    kind = KIND_STAR;
			CH_NEWLINE: kind = KIND_NEWLINE;
			default:    kind = KIND_OTHER;
		endcase
	end

	assign spacer = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) ||
		(ch == CH_NEWLINE) || (ch == CH_FF) || (ch == CH_VT);

	assign push_valid        = item_valid;
	assign item_ready        = push_ready;
	assign push_entry.ch     = ch;
	assign push_entry.kind   = kind;
	assign push_entry.spacer = spacer;
	assign push_entry.eot    = end_of_text;

endmodule

`default_nettype wire

/* rtl/core/escp_queue.sv */
`default_nettype none

module escp_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire escp_pkg::entry_t  push_entry,
	output logic                   head_valid,
	output escp_pkg::entry_t       head,
	input  wire logic              pop
);
	import escp_pkg::*;

	entry_t            slots_q [Q_DEPTH];
	logic [Q_AW-1:0]   wptr_q;
	logic [Q_AW-1:0]   rptr_q;
	logic [Q_CW-1:0]   count_q;
	logic              do_push;

	assign push_ready = (count_q != Q_CW'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rptr_q];
	assign do_push    = push_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/escp_back.sv */
`default_nettype none

module escp_back #(
	parameter int MAX_NEST  = 255,
	parameter int LINE_BITS = 24
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       head_valid,
	input  wire escp_pkg::entry_t           head,
	output logic                            pop,
	input  wire logic                       cfg_write,
	input  wire logic [escp_pkg::CFG_W-1:0] cfg_data,
	output logic                            result_valid,
	input  wire logic                       result_ready,
	output escp_pkg::evt_t                  result
);
	import escp_pkg::*;

	localparam int DW    = $clog2(MAX_NEST + 1);
	localparam int CMP_W = (LINE_BITS > CFG_W) ? LINE_BITS : CFG_W;
	localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

	// Step of the current byte.
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_EOT    = 2'd2;

	typedef struct packed {
		logic [DW-1:0]        depth;
		logic [2:0]           field;
		logic                 blk;
		logic                 lc;
		logic                 star;
		logic                 slash;
		logic                 bef;
		logic                 aft;
		logic                 has;
		logic                 argo;
		logic                 started;
		logic [LINE_BITS-1:0] line;
		logic [3:0]           err;
	} pstate_t;

	function automatic logic [LINE_BITS-1:0] clamp_line(input logic [CFG_W-1:0] v);
		logic [CMP_W-1:0] wide;
		wide = CMP_W'(v);
		if (wide > CMP_W'(LINE_TOP)) begin
			clamp_line = LINE_TOP;
		end else begin
			clamp_line = LINE_BITS'(v);
		end
	endfunction

	function automatic pstate_t init_state(input logic [LINE_BITS-1:0] l);
		pstate_t s;
		s         = '0;
		s.field   = F_KEYWORD;
		s.bef     = 1'b1;
		s.line    = l;
		return s;
	endfunction

	pstate_t          st_q;
	logic [CFG_W-1:0] fln_q;
	logic [1:0]       phase_q;
	logic             out_valid_q;
	evt_t             out_q;

	// Byte fed to the step unit: the held slash first, otherwise the queue head.
	logic [CHAR_W-1:0] pc_char;
	logic [3:0]        pc_kind;
	logic              pc_sp;

	always_comb begin
		if (phase_q == PH_FIRST && st_q.slash) begin
			pc_char = CH_SLASH;
			pc_kind = KIND_SLASH;
			pc_sp   = 1'b0;
		end else begin
			pc_char = head.ch;
			pc_kind = head.kind;
			pc_sp   = head.spacer;
		end
	end

	// Step unit: one byte through the parser, giving one event and the next state.
	pstate_t    pn;
	evt_t       pe;
	logic       do_mv;
	logic [2:0] mv_to;
	logic       do_app;
	logic       mark;
	logic [DW-1:0] dnext;

	always_comb begin
		pn     = st_q;
		pe     = '0;
		pe.line  = LINE_OUT_W'(st_q.line);
		pe.error = st_q.err;
		do_mv  = 1'b0;
		mv_to  = F_KEYWORD;
		do_app = 1'b0;
		mark   = 1'b0;
		dnext  = st_q.depth;
		if (st_q.err == ERR_NONE) begin
			if (pc_kind == KIND_NEWLINE && st_q.line != LINE_TOP) begin
				pn.line = st_q.line + 1'b1;
			end
			pe.line = LINE_OUT_W'(pn.line);
			if (st_q.depth != '0) begin
				if (pc_kind == KIND_LBRACE && st_q.depth >= DW'(MAX_NEST)) begin
					pn.err   = ERR_TOO_DEEP;
					pe.error = ERR_TOO_DEEP;
				end else begin
					if (pc_kind == KIND_LBRACE) begin
						dnext = st_q.depth + 1'b1;
					end else if (pc_kind == KIND_RBRACE) begin
						dnext = st_q.depth - 1'b1;
					end
					pn.depth = dnext;
					if (st_q.field == F_BODY && dnext != '0) begin
						do_app = 1'b1;
					end
					if (dnext == '0) begin
						do_mv = 1'b1;
						mv_to = F_KEYWORD;
						mark  = 1'b1;
					end
				end
			end else if (st_q.blk) begin
				if (st_q.star && pc_kind == KIND_SLASH) begin
					pn.blk  = 1'b0;
					pn.star = 1'b0;
				end else begin
					pn.star = (pc_kind == KIND_STAR);
				end
			end else if (st_q.lc) begin
				if (pc_kind == KIND_NEWLINE) begin
					pn.lc = 1'b0;
				end
			end else if (pc_kind == KIND_COLON) begin
				if (st_q.field == F_ARGS) begin
					pn.err   = ERR_COLON_IN_ARGS;
					pe.error = ERR_COLON_IN_ARGS;
				end else begin
					do_mv     = 1'b1;
					mv_to     = F_NAME;
					pe.marker = MARK_NAME;
					mark      = 1'b1;
				end
			end else if (pc_kind == KIND_LBRACE) begin
				if (st_q.field == F_ARGS) begin
					pn.err   = ERR_BRACE_IN_ARGS;
					pe.error = ERR_BRACE_IN_ARGS;
				end else begin
					do_mv     = 1'b1;
					mv_to     = F_BODY;
					pe.marker = MARK_BODY;
					mark      = 1'b1;
					pn.depth  = DW'(1);
				end
			end else if (pc_kind == KIND_RBRACE) begin
				pn.err   = ERR_STRAY_RBRACE;
				pe.error = ERR_STRAY_RBRACE;
			end else if (pc_kind == KIND_LPAREN) begin
				if (st_q.field == F_ARGS) begin
					pn.err   = ERR_PAREN_IN_ARGS;
					pe.error = ERR_PAREN_IN_ARGS;
				end else begin
					do_mv     = 1'b1;
					mv_to     = F_ARGS;
					pe.marker = MARK_ARGS;
					mark      = 1'b1;
				end
			end else if (pc_kind == KIND_COMMA) begin
				if (st_q.field != F_ARGS) begin
					pn.err   = ERR_STRAY_COMMA;
					pe.error = ERR_STRAY_COMMA;
				end else begin
					pe.start_argument = 1'b1;
					pn.argo = 1'b1;
					pn.has  = 1'b1;
					mark    = 1'b1;
				end
			end else if (pc_kind == KIND_RPAREN) begin
				if (st_q.field != F_ARGS) begin
					pn.err   = ERR_STRAY_RPAREN;
					pe.error = ERR_STRAY_RPAREN;
				end else begin
					pn.field = F_AFTER;
					mark     = 1'b1;
				end
			end else if (!pc_sp && !st_q.aft) begin
				if (st_q.field == F_AFTER) begin
					do_mv = 1'b1;
					mv_to = F_KEYWORD;
				end
				do_app = 1'b1;
				pn.bef = 1'b0;
			end else if (pc_sp && !st_q.aft && !st_q.bef) begin
				pn.aft = 1'b1;
			end else if (!pc_sp && st_q.aft) begin
				if (st_q.field == F_ARGS) begin
					pn.err   = ERR_MISSING_COMMA;
					pe.error = ERR_MISSING_COMMA;
				end else begin
					do_mv  = 1'b1;
					mv_to  = F_KEYWORD;
					do_app = 1'b1;
					pn.aft = 1'b0;
				end
			end
			// Moving to an earlier or the same field completes a non-empty element.
			if (do_mv) begin
				if (mv_to <= pn.field && pn.has) begin
					pe.close_element = 1'b1;
					pn.has  = 1'b0;
					pn.argo = 1'b0;
				end
				pn.field = mv_to;
			end
			if (do_app) begin
				pe.out_char = pc_char;
				pe.dest = (pn.field == F_BODY) ? DEST_BODY : pn.field + 3'd1;
				if (pn.field == F_ARGS && !pn.argo) begin
					pe.start_argument = 1'b1;
					pn.argo = 1'b1;
				end
				pn.has = 1'b1;
			end
			if (mark) begin
				pn.aft = 1'b0;
				pn.bef = 1'b1;
			end
		end
	end

	// Sequencer: picks what this cycle emits and how far the current byte has got.
	logic    step;
	logic    emit;
	logic    last;
	logic    done;
	evt_t    ce;
	evt_t    ev;
	pstate_t nst;
	logic [1:0] nphase;

	assign step = head_valid && (!out_valid_q || result_ready);

	always_comb begin
		ce       = '0;
		ce.line  = LINE_OUT_W'(st_q.line);
		ce.error = st_q.err;
		nst      = st_q;
		nst.started = 1'b1;
		ev       = ce;
		emit     = 1'b0;
		pop      = 1'b0;
		last     = 1'b0;
		done     = 1'b0;
		nphase   = phase_q;
		case (phase_q)
			PH_EOT: begin
				if (st_q.err == ERR_NONE) begin
					if (st_q.depth != '0) begin
						ev.error = ERR_MISSING_RBRACE;
					end else if (st_q.field == F_ARGS) begin
						ev.error = ERR_MISSING_RPAREN;
					end else if (st_q.has) begin
						ev.close_element = 1'b1;
					end
				end
				emit   = 1'b1;
				done   = 1'b1;
				last   = 1'b1;
				pop    = 1'b1;
				nst    = init_state(clamp_line(fln_q));
				nphase = PH_FIRST;
			end
			PH_SECOND: begin
				ev   = pe;
				nst  = pn;
				nst.started = 1'b1;
				emit = 1'b1;
				if (head.eot) begin
					nphase = PH_EOT;
				end else begin
					pop    = 1'b1;
					last   = 1'b1;
					nphase = PH_FIRST;
				end
			end
			default: begin
				if (st_q.slash) begin
					if (head.kind == KIND_STAR || head.kind == KIND_SLASH) begin
						// The held slash opens a comment.
						emit      = 1'b1;
						nst.slash = 1'b0;
						if (head.kind == KIND_STAR) begin
							nst.blk  = 1'b1;
							nst.star = 1'b0;
						end else begin
							nst.lc = 1'b1;
						end
						if (head.eot) begin
							nphase = PH_EOT;
						end else begin
							pop  = 1'b1;
							last = 1'b1;
						end
					end else begin
						// The held slash was an ordinary byte; this byte follows in the second phase.
						ev        = pe;
						nst       = pn;
						nst.started = 1'b1;
						nst.slash = 1'b0;
						emit      = 1'b1;
						nphase    = PH_SECOND;
					end
				end else if (head.kind == KIND_SLASH && !head.eot && st_q.err == ERR_NONE &&
						st_q.depth == '0 && !st_q.blk && !st_q.lc) begin
					nst.slash = 1'b1;
					pop       = 1'b1;
				end else begin
					ev   = pe;
					nst  = pn;
					nst.started = 1'b1;
					emit = 1'b1;
					if (head.eot) begin
						nphase = PH_EOT;
					end else begin
						pop  = 1'b1;
						last = 1'b1;
					end
				end
			end
		endcase
		ev.stream_done  = done;
		ev.last_of_item = last;
		if (!step) begin
			pop = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= init_state(clamp_line(CFG_W'(1)));
			fln_q       <= CFG_W'(1);
			phase_q     <= PH_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			// The user must write the register only while no byte is being worked on; the block does not enforce it.
			if (step) begin
				st_q    <= nst;
				phase_q <= nphase;
			end else if (cfg_write && !st_q.started) begin
				st_q.line <= clamp_line(cfg_data);
			end
			if (step && emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				fln_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_q <= ev;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

/* rtl/core/element_script_char_parser_unit.sv */
`default_nettype none

// Streaming parser for script text of the form keyword:name(arg, arg){body}. One byte of
// text is taken per item on the input channel, and each byte turns into events on the
// result channel: append a byte to a field, open an argument, complete an element, set a
// field marker, or report an error. Errors are sticky until the end of the text, after
// which the parser returns to its start state, ready for a new stream; the line number
// register (cfg_data, written on the configuration channel while the block is idle)
// gives the line of the first byte of each stream and also reloads the counter if the
// current stream has not begun. The block takes one byte per cycle in steady state, when
// the result channel does not stall and no byte yields extra events. A byte normally
// yields one event; a held '/' that turns out not to open a comment yields two events
// with the following byte, and the last byte of a text yields one further event carrying
// stream_done. Events are produced one per cycle, while the result channel does not
// stall, by the single step unit in the back end. A held '/' is taken by the step unit on
// its own without giving an event. A four-entry queue between the byte classifier and
// the step unit absorbs the extra work, and the result register holds each event until
// it is taken; the step unit waits while the register is full and not being taken. An
// accepted byte is written into the queue and its first event then goes into the result
// register.
module element_script_char_parser_unit #(
	parameter int MAX_NEST  = 255,
	parameter int LINE_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Byte channel.
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire logic [escp_pkg::CHAR_W-1:0]     ch,
	input  wire logic                            end_of_text,
	// Event channel.
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output logic [escp_pkg::CHAR_W-1:0]          out_char,
	output logic [2:0]                           dest,
	output logic                                 start_argument,
	output logic                                 close_element,
	output logic [1:0]                           marker,
	output logic [escp_pkg::LINE_OUT_W-1:0]      line,
	output logic [3:0]                           error,
	output logic                                 stream_done,
	output logic                                 last_of_item,
	// Configuration channel: first line number.
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [escp_pkg::CFG_W-1:0]      cfg_data
);
	import escp_pkg::*;

	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;
	logic   head_valid;
	entry_t head;
	logic   pop;
	evt_t   result;

	// The register write is always taken at once.
	assign cfg_ready = 1'b1;

	// Front end: classifies each byte and pushes it into the queue.
	escp_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.ch         (ch),
		.end_of_text(end_of_text),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// Short queue so that a byte with several events does not stall the input side.
	escp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	// Back end: parser state, comment handling, end-of-text checks and the result register.
	escp_back #(
		.MAX_NEST (MAX_NEST),
		.LINE_BITS(LINE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	assign out_char       = result.out_char;
	assign dest           = result.dest;
	assign start_argument = result.start_argument;
	assign close_element  = result.close_element;
	assign marker         = result.marker;
	assign line           = result.line;
	assign error          = result.error;
	assign stream_done    = result.stream_done;
	assign last_of_item   = result.last_of_item;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import escp_pkg::*;

	// The block is built with its default nesting bound and line counter width, and the
	// prediction below assumes the same values.
	localparam int          MAX_NEST      = 255;
	localparam logic [23:0] LINE_TOP      = 24'hFFFFFF;
	localparam int          SETTLE_CYCLES = 12;
	localparam int          END_CYCLES    = 30;
	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          PHASE_ITEMS   = 40;

	typedef logic [7:0] byte_queue_t[$];

	// Keeps its own copy of the parser state, works out the events that each accepted
	// byte should cause and compares every event the block hands out with the oldest
	// one still outstanding.
	class element_event_tracker;
		logic [23:0] first_line;
		logic [23:0] line_count;
		int          depth;
		logic [2:0]  field;
		bit          in_block, in_line, star_seen, slash_held;
		bit          before_tok, after_tok, has_content, arg_open, started;
		logic [3:0]  err_latched;
		evt_t        outstanding[$];
		int          failures;

		function new();
			first_line = 24'd1;
			failures   = 0;
			restart();
		endfunction

		function void restart();
			depth       = 0;
			field       = F_KEYWORD;
			in_block    = 1'b0;
			in_line     = 1'b0;
			star_seen   = 1'b0;
			slash_held  = 1'b0;
			before_tok  = 1'b1;
			after_tok   = 1'b0;
			has_content = 1'b0;
			arg_open    = 1'b0;
			line_count  = first_line;
			err_latched = ERR_NONE;
			started     = 1'b0;
		endfunction

		function int pending();
			return outstanding.size();
		endfunction

		// A write reloads the counter only while the current stream has taken no byte.
		function void load_first_line(input logic [23:0] value);
			first_line = value;
			if (!started) line_count = value;
		endfunction

		function evt_t blank();
			evt_t ev;
			ev       = '0;
			ev.line  = line_count;
			ev.error = err_latched;
			return ev;
		endfunction

		function void raise_error(inout evt_t ev, input logic [3:0] code);
			err_latched = code;
			ev.error    = code;
		endfunction

		// Moving back to an earlier field (or staying) completes an element that has content.
		function void move_field(inout evt_t ev, input logic [2:0] next);
			if (next <= field && has_content) begin
				ev.close_element = 1'b1;
				has_content      = 1'b0;
				arg_open         = 1'b0;
			end
			field = next;
		endfunction

		function void append(inout evt_t ev, input logic [7:0] c);
			ev.out_char = c;
			ev.dest     = (field == F_BODY) ? DEST_BODY : field + 3'd1;
			if (field == F_ARGS && !arg_open) begin
				ev.start_argument = 1'b1;
				arg_open          = 1'b1;
			end
			has_content = 1'b1;
		endfunction

		function void mark_start();
			after_tok  = 1'b0;
			before_tok = 1'b1;
		endfunction

		function evt_t parse_char(input logic [7:0] c);
			evt_t ev;
			bit   spacer;
			spacer = (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NEWLINE ||
				c == CH_FF || c == CH_VT);
			ev = blank();
			if (err_latched != ERR_NONE) return ev;
			if (c == CH_NEWLINE && line_count != LINE_TOP) line_count++;
			ev.line = line_count;
			if (depth > 0) begin
				if (c == CH_LBRACE) begin
					if (depth >= MAX_NEST) begin
						raise_error(ev, ERR_TOO_DEEP);
						return ev;
					end
					depth++;
				end else if (c == CH_RBRACE) begin
					depth--;
				end
				if (field == F_BODY && depth > 0) append(ev, c);
				if (depth == 0) begin
					move_field(ev, F_KEYWORD);
					mark_start();
				end
			end else if (in_block) begin
				if (star_seen && c == CH_SLASH) begin
					in_block  = 1'b0;
					star_seen = 1'b0;
				end else begin
					star_seen = (c == CH_STAR);
				end
			end else if (in_line) begin
				if (c == CH_NEWLINE) in_line = 1'b0;
			end else if (c == CH_COLON) begin
				if (field == F_ARGS) begin
					raise_error(ev, ERR_COLON_IN_ARGS);
					return ev;
				end
				move_field(ev, F_NAME);
				ev.marker = MARK_NAME;
				mark_start();
			end else if (c == CH_LBRACE) begin
				if (field == F_ARGS) begin
					raise_error(ev, ERR_BRACE_IN_ARGS);
					return ev;
				end
				move_field(ev, F_BODY);
				ev.marker = MARK_BODY;
				mark_start();
				depth = 1;
			end else if (c == CH_RBRACE) begin
				raise_error(ev, ERR_STRAY_RBRACE);
			end else if (c == CH_LPAREN) begin
				if (field == F_ARGS) begin
					raise_error(ev, ERR_PAREN_IN_ARGS);
					return ev;
				end
				move_field(ev, F_ARGS);
				ev.marker = MARK_ARGS;
				mark_start();
			end else if (c == CH_COMMA) begin
				if (field != F_ARGS) begin
					raise_error(ev, ERR_STRAY_COMMA);
					return ev;
				end
				ev.start_argument = 1'b1;
				arg_open          = 1'b1;
				has_content       = 1'b1;
				mark_start();
			end else if (c == CH_RPAREN) begin
				if (field != F_ARGS) begin
					raise_error(ev, ERR_STRAY_RPAREN);
					return ev;
				end
				field = F_AFTER;
				mark_start();
			end else if (!spacer && !after_tok) begin
				if (field == F_AFTER) move_field(ev, F_KEYWORD);
				append(ev, c);
				before_tok = 1'b0;
			end else if (spacer && !after_tok && !before_tok) begin
				after_tok = 1'b1;
			end else if (!spacer && after_tok) begin
				if (field == F_ARGS) begin
					raise_error(ev, ERR_MISSING_COMMA);
					return ev;
				end
				move_field(ev, F_KEYWORD);
				append(ev, c);
				after_tok = 1'b0;
			end
			return ev;
		endfunction

		function void predict_byte(input logic [7:0] c, input logic eot);
			evt_t evs[$];
			evt_t ev;
			started = 1'b1;
			if (slash_held) begin
				slash_held = 1'b0;
				if (c == CH_STAR) begin
					in_block  = 1'b1;
					star_seen = 1'b0;
					evs.insert(evs.size(), blank());
				end else if (c == CH_SLASH) begin
					in_line = 1'b1;
					evs.insert(evs.size(), blank());
				end else begin
					evs.insert(evs.size(), parse_char(CH_SLASH));
					evs.insert(evs.size(), parse_char(c));
				end
			end else if (c == CH_SLASH && !eot && err_latched == ERR_NONE && depth == 0 &&
				!in_block && !in_line) begin
				slash_held = 1'b1;
				return;
			end else begin
				evs.insert(evs.size(), parse_char(c));
			end
			if (eot) begin
				ev = blank();
				if (err_latched == ERR_NONE) begin
					if (depth > 0) raise_error(ev, ERR_MISSING_RBRACE);
					else if (field == F_ARGS) raise_error(ev, ERR_MISSING_RPAREN);
					else if (has_content) ev.close_element = 1'b1;
				end
				ev.stream_done = 1'b1;
				evs.insert(evs.size(), ev);
				restart();
			end
			for (int i = 0; i < evs.size(); i++) begin
				ev              = evs[i];
				ev.last_of_item = (i == evs.size() - 1);
				outstanding.insert(outstanding.size(), ev);
			end
		endfunction

		function void compare(input string what, input logic [31:0] want,
			input logic [31:0] got);
			if (want !== got) begin
				failures++;
				$display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
			end
		endfunction

		function void check_event(input evt_t got);
			evt_t want;
			if (outstanding.size() == 0) begin
				failures++;
				$display("%0t: event with none expected, expected nothing, actual %h",
					$time, got);
				return;
			end
			want = outstanding.pop_front();
			compare("out_char", want.out_char, got.out_char);
			compare("dest", want.dest, got.dest);
			compare("start_argument", want.start_argument, got.start_argument);
			compare("close_element", want.close_element, got.close_element);
			compare("marker", want.marker, got.marker);
			compare("line", want.line, got.line);
			compare("error", want.error, got.error);
			compare("stream_done", want.stream_done, got.stream_done);
			compare("last_of_item", want.last_of_item, got.last_of_item);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [7:0]  ch;
	logic        end_of_text;
	logic        result_valid;
	logic        result_ready;
	logic [7:0]  out_char;
	logic [2:0]  dest;
	logic        start_argument;
	logic        close_element;
	logic [1:0]  marker;
	logic [23:0] line;
	logic [3:0]  error;
	logic        stream_done;
	logic        last_of_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [23:0] cfg_data;

	element_event_tracker tracker;
	byte_queue_t          script;
	int                   items_sent = 0;
	int                   cycles     = 0;
	bit                   sender_calm   = 1'b0;
	bit                   receiver_calm = 1'b0;

	// The configuration channel carries the single register, the first line number, so
	// no index travels with it.
	element_script_char_parser_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.ch             (ch),
		.end_of_text    (end_of_text),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.out_char       (out_char),
		.dest           (dest),
		.start_argument (start_argument),
		.close_element  (close_element),
		.marker         (marker),
		.line           (line),
		.error          (error),
		.stream_done    (stream_done),
		.last_of_item   (last_of_item),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always #10 clk = ~clk;

	// A hung handshake or a lost event would otherwise leave the run waiting for ever.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Events are sampled at the rising edge, where the values seen are those that were
	// settled before the edge, so the outcome does not hang on process order.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			tracker.check_event({out_char, dest, start_argument, close_element, marker,
				line, error, stream_done, last_of_item});
	end

	// The receiver draws a stall for every event and then holds ready high until the
	// event has been taken. Now and then it falls into a calm stretch with no stalls.
	initial begin : receiver
		int stall;
		result_ready = 1'b0;
		forever begin
			if ($urandom_range(0, 19) == 0) receiver_calm = !receiver_calm;
			stall = receiver_calm ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// Sends one byte. The task is entered at a falling edge and leaves at the falling edge
	// after acceptance with valid still high, so that a byte sent straight after keeps
	// valid high instead of dropping and raising it within the same step.
	task automatic send_byte(input logic [7:0] c, input logic last);
		int gap;
		if ($urandom_range(0, 19) == 0) sender_calm = !sender_calm;
		gap = sender_calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid  <= 1'b1;
		ch          <= c;
		end_of_text <= last;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		tracker.predict_byte(c, last);
		items_sent++;
		@(negedge clk);
	endtask

	// Sends the text built up so far, with end of text flagged on its last byte.
	task automatic send_script();
		for (int i = 0; i < script.size(); i++)
			send_byte(script[i], i == script.size() - 1);
		script.delete();
	endtask

	// Holds the sender back until every expected event has arrived, then gives a held
	// slash or a late event some cycles to show up.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_first_line(input logic [23:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.load_first_line(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void put_byte(input logic [7:0] b);
		script.insert(script.size(), b);
	endfunction

	function automatic void put_str(input string s);
		for (int i = 0; i < s.len(); i++) script.insert(script.size(), s[i]);
	endfunction

	function automatic bit is_reserved(input logic [7:0] b);
		case (b)
			CH_COLON, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_COMMA, CH_RPAREN, CH_SLASH,
			CH_STAR, CH_NEWLINE, CH_SPACE, CH_TAB, CH_CR, CH_FF, CH_VT: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] special_byte();
		case ($urandom_range(0, 9))
			0: return CH_COLON;
			1: return CH_LBRACE;
			2: return CH_RBRACE;
			3: return CH_LPAREN;
			4: return CH_COMMA;
			5: return CH_RPAREN;
			6: return CH_SLASH;
			7: return CH_STAR;
			8: return CH_NEWLINE;
			default: return CH_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] spacer_byte();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			3: return CH_NEWLINE;
			4: return CH_FF;
			default: return CH_VT;
		endcase
	endfunction

	// Token bytes are half plain letters and half any byte without a meaning to the parser.
	function automatic logic [7:0] token_byte();
		logic [7:0] b;
		if ($urandom_range(0, 1)) return 8'h61 + 8'($urandom_range(0, 25));
		do b = 8'($urandom_range(0, 255)); while (is_reserved(b));
		return b;
	endfunction

	function automatic void put_token();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) put_byte(token_byte());
	endfunction

	function automatic void put_spaces();
		int n;
		n = $urandom_range(0, 2);
		repeat (n) put_byte(spacer_byte());
	endfunction

	// Whitespace or a comment between elements. Comment text never holds a slash, so a
	// block comment ends only where it is meant to.
	function automatic void put_gap();
		int n;
		n = $urandom_range(0, 5);
		case ($urandom_range(0, 3))
			0: ;
			1: put_spaces();
			2: begin
				put_byte(CH_SLASH);
				put_byte(CH_STAR);
				repeat (n) put_byte($urandom_range(0, 2) == 0 ? CH_STAR : token_byte());
				put_byte(CH_STAR);
				put_byte(CH_SLASH);
			end
			default: begin
				put_byte(CH_SLASH);
				put_byte(CH_SLASH);
				repeat (n) put_byte(token_byte());
				put_byte(CH_NEWLINE);
			end
		endcase
	endfunction

	// A body with balanced nested braces around bytes of any value but braces.
	function automatic void put_body();
		int         n;
		int         level;
		logic [7:0] b;
		level = 0;
		n     = $urandom_range(0, 8);
		put_byte(CH_LBRACE);
		repeat (n) begin
			case ($urandom_range(0, 5))
				0: begin
					if (level < 3) begin
						put_byte(CH_LBRACE);
						level++;
					end
				end
				1: begin
					if (level > 0) begin
						put_byte(CH_RBRACE);
						level--;
					end
				end
				default: begin
					b = 8'($urandom_range(0, 255));
					put_byte((b == CH_LBRACE || b == CH_RBRACE) ? 8'h78 : b);
				end
			endcase
		end
		repeat (level) put_byte(CH_RBRACE);
		put_byte(CH_RBRACE);
	endfunction

	function automatic void put_element();
		int n;
		put_token();
		if ($urandom_range(0, 4) == 0) begin
			put_byte(CH_SPACE);
			put_token();
		end
		if ($urandom_range(0, 1)) begin
			put_spaces();
			put_byte(CH_COLON);
			put_spaces();
			put_token();
		end
		if ($urandom_range(0, 1)) begin
			put_byte(CH_LPAREN);
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				if (i > 0) put_byte(CH_COMMA);
				put_spaces();
				put_token();
				put_spaces();
			end
			put_byte(CH_RPAREN);
		end
		if ($urandom_range(0, 1)) put_body();
		put_gap();
	endfunction

	// Most streams are well formed so that they reach the body and argument states; some
	// have one byte replaced by a punctuation byte, and a few are plain noise.
	function automatic void put_random_stream();
		int n;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			n = $urandom_range(1, 12);
			repeat (n) put_byte($urandom_range(0, 1) ? special_byte() : 8'($urandom_range(0, 255)));
		end else begin
			put_gap();
			n = $urandom_range(1, 3);
			repeat (n) put_element();
			if (kind >= 7) script[$urandom_range(0, script.size() - 1)] = special_byte();
		end
	endfunction

	initial begin : stimulus
		string       broken_texts[9];
		logic [23:0] phase_lines[4];
		int          phase_start;

		broken_texts = '{"(:\nz", "({\nz", "}\nz", "((\nz", ",\nz", ")\nz", "(a b\nz",
			"k{", "k("};
		phase_lines  = '{24'hFFFFFF, 24'hFFFFF0, 24'd1, 24'($urandom_range(0, 24'hFFFFFF))};

		tracker     = new();
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		ch          = '0;
		end_of_text = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every field and operation in one element, with nested braces in the body.
		put_str("k:n(a, b){x{y}z}");
		send_script();
		// A slash that is only division, a block comment, a line comment, and a slash as
		// the final byte, which is taken as an ordinary byte.
		put_str("a/b/*c**/d//e\n/");
		send_script();
		// Byte extremes, with and without spacing between them.
		put_byte(8'h00);
		put_byte(CH_SPACE);
		put_byte(8'hFF);
		put_byte(8'hFF);
		send_script();
		// Markers on an element with no content, which must never be completed.
		put_str("::()");
		send_script();
		// Each error in a stream of its own; where a newline and byte follow the error, they show
		// that the error sticks and the line counter stops.
		foreach (broken_texts[i]) begin
			put_str(broken_texts[i]);
			send_script();
		end

		// The line counter saturates at the top of its range.
		write_first_line(24'hFFFFFE);
		put_str("\n\n\nq\n");
		send_script();
		write_first_line(24'h000000);
		put_str("q\nr(s)");
		send_script();

		// Random phases, each under a line number of its own. Each write happens only once
		// all events have come, so the sender pauses at every phase boundary.
		foreach (phase_lines[p]) begin
			write_first_line(phase_lines[p]);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				put_random_stream();
				send_script();
			end
		end

		wait_idle();
		repeat (END_CYCLES) @(negedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
